FILE: sv/adc_pkg.sv
// Shared types and constants for the access decision cache.
package adc_pkg;

  localparam int DEF_SLOT_COUNT     = 256;
  localparam int DEF_ENTRY_CAPACITY = 180;
  localparam int HASH_W             = 32;
  localparam int CLASS_SHIFT        = 3;

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_FILL  = 2'd1,
    OP_INVAL = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECLAIM,
    ST_LOOKUP,
    ST_DECIDE,
    ST_RESP
  } eng_state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] target_sid;
    logic [15:0] object_class;
    logic [31:0] required_perms;
    logic [31:0] fill_allowed;
    logic [31:0] fill_audit_allow;
    logic [31:0] fill_audit_deny;
    logic        new_enforcing;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic        granted;
    logic [31:0] denied_mask;
    logic [31:0] audited_mask;
    logic        audit_is_denial;
  } out_t;

endpackage

FILE: sv/access_decision_cache_unit.sv
// Access decision cache: a check scans the ENTRY_CAPACITY+1 entry store once, one entry per
// cycle through the store's single read port; the back end takes the next command only once
// its result word has gone into the result queue. A fill also passes slot reduction in the
// front and, when the store is over capacity, a reclaim sweep over one slot after another
// until it is back within capacity. Invalidate and the unused opcode skip the scan and answer
// directly. The front takes the next word once the last one, after slot reduction for a fill,
// has gone into a two-word command queue. A result word waits in a two-word queue while the
// next request is taken. No clearing pass is needed after reset.
module access_decision_cache_unit #(
  parameter int SLOT_COUNT     = adc_pkg::DEF_SLOT_COUNT,
  parameter int ENTRY_CAPACITY = adc_pkg::DEF_ENTRY_CAPACITY
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  adc_pkg::in_t  in_data,
  output logic          full,
  input  logic          pop,
  output adc_pkg::out_t out_data,
  output logic          empty
);
  import adc_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  in_t           q_cmd;
  logic [SW-1:0] q_slot;
  logic          q_pop, q_empty, res_full, res_push;
  out_t          res_data;
  logic [$bits(out_t)-1:0] out_raw;

  adc_front #(.SLOT_COUNT(SLOT_COUNT), .SW(SW)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .in_data(in_data),
    .full   (full),
    .q_pop  (q_pop),
    .q_cmd  (q_cmd),
    .q_slot (q_slot),
    .q_empty(q_empty)
  );

  adc_engine #(
    .SLOT_COUNT(SLOT_COUNT), .ENTRY_CAPACITY(ENTRY_CAPACITY), .SW(SW)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (q_cmd),
    .q_slot  (q_slot),
    .q_pop   (q_pop),
    .res_full(res_full),
    .res_push(res_push),
    .res_data(res_data)
  );

  adc_fifo #(.W($bits(out_t))) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_data),
    .full     (res_full),
    .pop      (pop),
    .pop_data (out_raw),
    .empty    (empty)
  );

  assign out_data = out_t'(out_raw);
endmodule

FILE: sv/adc_fifo.sv
// Two-word queue used between the stages and at the result side.
module adc_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end
endmodule

FILE: sv/adc_front.sv
// Front end: takes request words, reduces the key hash to a slot for fills, queues commands.
module adc_front #(
  parameter int SLOT_COUNT = adc_pkg::DEF_SLOT_COUNT,
  parameter int SW         = $clog2(SLOT_COUNT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  adc_pkg::in_t  in_data,
  output logic          full,
  input  logic          q_pop,
  output adc_pkg::in_t  q_cmd,
  output logic [SW-1:0] q_slot,
  output logic          q_empty
);
  import adc_pkg::*;

  localparam int QW = $bits(in_t) + SW;
  // floor(2^(32+SW) / SLOT_COUNT), below 2^33
  localparam logic [64:0] RECIP     = (65'd1 << (32 + SW)) / 65'(SLOT_COUNT);
  localparam logic [2:0]  RED_STEPS = 3'd4;

  logic              busy_r, busy_nxt;
  in_t               hold_r;
  logic [HASH_W-1:0] hash_r;
  logic [64:0]       prod_r, prod_nxt;
  logic [31:0]       quo, qn_r, qn_nxt;
  logic [SW:0]       diff_r, diff_nxt;
  logic [SW-1:0]     rem_r, rem_nxt;
  logic [2:0]        cnt_r;
  logic              accept, is_fill, done, q_push, q_full, iter;
  logic [QW-1:0]     q_out;

  assign full    = busy_r;
  assign accept  = push && !busy_r;
  assign is_fill = (op_t'(hold_r.opcode) == OP_FILL);
  assign iter    = busy_r && is_fill && (cnt_r != RED_STEPS);
  assign done    = busy_r && !iter;
  assign q_push  = done && !q_full;

  // hash mod SLOT_COUNT by reciprocal multiply: the quotient estimate is low
  // by at most one, so one conditional subtract finishes it; one stage per cycle
  always_comb begin
    prod_nxt = 65'(hash_r) * RECIP;
    quo      = 32'(prod_r >> (32 + SW));
    qn_nxt   = quo * 32'(SLOT_COUNT);
    diff_nxt = (SW+1)'(hash_r - qn_r);
    rem_nxt  = (diff_r >= (SW+1)'(SLOT_COUNT)) ? SW'(diff_r - (SW+1)'(SLOT_COUNT))
                                               : diff_r[SW-1:0];
    busy_nxt = accept ? 1'b1 : (q_push ? 1'b0 : busy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= busy_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= in_data;
      hash_r <= in_data.target_sid ^ {13'd0, in_data.object_class, 3'd0};
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (iter) begin
      prod_r <= prod_nxt;
      qn_r   <= qn_nxt;
      diff_r <= diff_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_r + 3'd1;
    end
  end

  adc_fifo #(.W(QW)) u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data({rem_r, hold_r}),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  assign q_cmd  = in_t'(q_out[$bits(in_t)-1:0]);
  assign q_slot = q_out[QW-1:$bits(in_t)];
endmodule

FILE: sv/adc_engine.sv
// Back end: entry store, lookup scan, second-chance reclaim and decision.
module adc_engine #(
  parameter int SLOT_COUNT     = adc_pkg::DEF_SLOT_COUNT,
  parameter int ENTRY_CAPACITY = adc_pkg::DEF_ENTRY_CAPACITY,
  parameter int SW             = $clog2(SLOT_COUNT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  adc_pkg::in_t  q_cmd,
  input  logic [SW-1:0] q_slot,
  output logic          q_pop,
  input  logic          res_full,
  output logic          res_push,
  output adc_pkg::out_t res_data
);
  import adc_pkg::*;

  localparam int DEPTH = ENTRY_CAPACITY + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [SW-1:0] slot;
    logic [31:0]   sid;
    logic [15:0]   cls;
    logic [31:0]   allowed;
    logic [31:0]   aud_allow;
    logic [31:0]   aud_deny;
  } ent_t;

  ent_t mem [DEPTH];
  ent_t rd_r;
  ent_t ent_r, ent_nxt;
  ent_t wr_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  eng_state_t    state_r, state_nxt;
  in_t           cmd_r, cmd_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [DEPTH-1:0] valid_r, valid_nxt, hot_r, hot_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] sweep_r, sweep_nxt;
  logic          enf_r, enf_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic          dv_r, dv_nxt;
  logic [AW-1:0] didx_r, didx_nxt;
  logic          found_r, found_nxt, free_ok_r, free_ok_nxt;
  logic [AW-1:0] fidx_r, fidx_nxt, free_r, free_nxt;
  out_t          res_r, res_nxt;
  logic          scan_done, over_cap, cond;
  logic [31:0]   req, denied, eff_allowed;

  assign scan_done = (scan_r == CW'(DEPTH)) && !dv_r;
  assign over_cap  = count_r > CW'(ENTRY_CAPACITY);
  assign rd_addr   = scan_r[AW-1:0];
  assign res_data  = res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (op_t'(q_cmd.opcode))
            OP_CHECK: state_nxt = ST_LOOKUP;
            OP_FILL:  state_nxt = over_cap ? ST_RECLAIM : ST_LOOKUP;
            OP_INVAL: state_nxt = ST_RESP;
            OP_NOP:   state_nxt = ST_RESP;
            default:  state_nxt = ST_RESP;
          endcase
        end
      end
      ST_RECLAIM: if (scan_done && !over_cap) state_nxt = ST_LOOKUP;
      ST_LOOKUP:  if (scan_done) state_nxt = ST_DECIDE;
      ST_DECIDE:  state_nxt = ST_RESP;
      ST_RESP:    if (!res_full) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // decision for the entry at hand; a fill answers from its own fields
  always_comb begin
    req         = cmd_r.required_perms;
    eff_allowed = (op_t'(cmd_r.opcode) == OP_FILL) ? cmd_r.fill_allowed : ent_r.allowed;
    denied      = req & ~eff_allowed;
    cond        = (req == 32'd0) || (denied != 32'd0);
  end

  // datapath
  always_comb begin
    cmd_nxt     = cmd_r;
    slot_nxt    = slot_r;
    valid_nxt   = valid_r;
    hot_nxt     = hot_r;
    count_nxt   = count_r;
    sweep_nxt   = sweep_r;
    enf_nxt     = enf_r;
    scan_nxt    = scan_r;
    dv_nxt      = 1'b0;
    didx_nxt    = didx_r;
    found_nxt   = found_r;
    free_ok_nxt = free_ok_r;
    fidx_nxt    = fidx_r;
    free_nxt    = free_r;
    ent_nxt     = ent_r;
    res_nxt     = res_r;
    q_pop       = 1'b0;
    res_push    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = fidx_r;
    wr_data     = ent_r;

    if (state_r == ST_RECLAIM || state_r == ST_LOOKUP) begin
      if (scan_r != CW'(DEPTH)) begin
        dv_nxt   = 1'b1;
        didx_nxt = scan_r[AW-1:0];
        scan_nxt = scan_r + CW'(1);
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cmd_nxt     = q_cmd;
          slot_nxt    = q_slot;
          scan_nxt    = '0;
          found_nxt   = 1'b0;
          free_ok_nxt = 1'b0;
          res_nxt     = '0;
          if (op_t'(q_cmd.opcode) == OP_INVAL) begin
            valid_nxt = '0;
            count_nxt = '0;
            sweep_nxt = '0;
            enf_nxt   = q_cmd.new_enforcing;
          end
        end
      end
      ST_RECLAIM: begin
        if (dv_r && valid_r[didx_r] && rd_r.slot == sweep_r) begin
          if (hot_r[didx_r]) begin
            hot_nxt[didx_r] = 1'b0;
          end else begin
            valid_nxt[didx_r] = 1'b0;
            count_nxt         = count_r - CW'(1);
          end
        end
        if (scan_done) begin
          sweep_nxt = (sweep_r == SW'(SLOT_COUNT - 1)) ? '0 : sweep_r + SW'(1);
          scan_nxt  = '0;
        end
      end
      ST_LOOKUP: begin
        if (dv_r) begin
          if (valid_r[didx_r] && rd_r.sid == cmd_r.target_sid
              && rd_r.cls == cmd_r.object_class && !found_r) begin
            found_nxt = 1'b1;
            fidx_nxt  = didx_r;
            ent_nxt   = rd_r;
          end
          if (!valid_r[didx_r] && !free_ok_r) begin
            free_ok_nxt = 1'b1;
            free_nxt    = didx_r;
          end
        end
      end
      ST_DECIDE: begin
        if (op_t'(cmd_r.opcode) == OP_FILL || found_r) begin
          wr_en   = 1'b1;
          wr_addr = (op_t'(cmd_r.opcode) == OP_FILL && !found_r) ? free_r : fidx_r;
          if (op_t'(cmd_r.opcode) == OP_FILL) begin
            wr_data.slot      = slot_r;
            wr_data.sid       = cmd_r.target_sid;
            wr_data.cls       = cmd_r.object_class;
            wr_data.aud_allow = cmd_r.fill_audit_allow;
            wr_data.aud_deny  = cmd_r.fill_audit_deny;
            if (!found_r) count_nxt = count_r + CW'(1);
          end
          wr_data.allowed    = (cond && !enf_r) ? (eff_allowed | req) : eff_allowed;
          valid_nxt[wr_addr] = 1'b1;
          hot_nxt[wr_addr]   = 1'b1;
          res_nxt.hit             = 1'b1;
          res_nxt.granted         = !(cond && enf_r);
          res_nxt.denied_mask     = denied;
          res_nxt.audited_mask    = (denied != 32'd0) ? (denied & wr_data.aud_deny)
                                                      : (req & wr_data.aud_allow);
          res_nxt.audit_is_denial = (denied != 32'd0);
        end
      end
      ST_RESP: res_push = !res_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      count_r <= '0;
      sweep_r <= '0;
      enf_r   <= 1'b1;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      sweep_r <= sweep_nxt;
      enf_r   <= enf_nxt;
      dv_r    <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    slot_r    <= slot_nxt;
    hot_r     <= hot_nxt;
    scan_r    <= scan_nxt;
    didx_r    <= didx_nxt;
    found_r   <= found_nxt;
    free_ok_r <= free_ok_nxt;
    fidx_r    <= fidx_nxt;
    free_r    <= free_nxt;
    ent_r     <= ent_nxt;
    res_r     <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end
endmodule
